// File: rtl/core/skeletal_vertex_transform_core_macros.svh
// ----------------------------------------------------------------------------
// skeletal vertex transform core assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SKELETAL_VERTEX_TRANSFORM_CORE_MACROS_SVH
`define SKELETAL_VERTEX_TRANSFORM_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising edge, quiet in reset
`define SVT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svt check failed");

// next-cycle implication
`define SVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svt check failed");

`endif

// File: rtl/core/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg
// shared types, constants and helpers of the skeletal vertex transform core
// ----------------------------------------------------------------------------
package svt_pkg;

  localparam int COORD_W       = 20;
  localparam int PARAM_W       = 16;
  localparam int SUM_W         = 33;
  localparam int MAX_GROUP_VERTICES = 4096;
  localparam int COUNT_W       = 13;
  localparam int DIV_STEPS     = 32;
  localparam int DIV_CNT_W     = 5;
  localparam int TRIG_ENTRIES  = 2048;
  localparam int TRIG_W        = 11;
  localparam int QUARTER       = TRIG_ENTRIES / 4;
  localparam int QADDR_W       = 10;
  localparam int TRIG_VAL_W    = 17;
  localparam int D_W           = 23;
  localparam int MUL_B_W       = 18;
  localparam int PROD_W        = D_W + MUL_B_W;
  localparam real PI_R         = 3.14159265358979323846;
  // angle of one rom step in radians
  localparam real QSTEP_R      = PI_R / (2.0 * QUARTER);

  // command codes on the input channel
  localparam logic [2:0] CMD_ACC    = 3'd0;
  localparam logic [2:0] CMD_FINISH = 3'd1;
  localparam logic [2:0] CMD_TRANS  = 3'd2;
  localparam logic [2:0] CMD_ROT    = 3'd3;
  localparam logic [2:0] CMD_SCALE  = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_CLEAR,
    OP_TRANS,
    OP_ROM,
    OP_ROT,
    OP_ROT_OUT,
    OP_SC_MUL,
    OP_SC_ADD,
    OP_PUB
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
    logic [2:0] step;
  } dp_cmd_t;

  typedef logic [TRIG_VAL_W-1:0] qrom_t [QUARTER+1];

  // quarter sine wave in unsigned 1.16, truncated toward zero
  function automatic qrom_t build_qrom();
    qrom_t t;
    real   a;
    for (int k = 0; k <= QUARTER; k++) begin
      a    = $sin(QSTEP_R * k) * 65536.0;
      t[k] = TRIG_VAL_W'($rtoi(a));
    end
    t[QUARTER] = TRIG_VAL_W'(65536);
    return t;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd524287;
    lo = -48'sd524288;
    if (v > hi) return COORD_W'(hi);
    if (v < lo) return COORD_W'(lo);
    return v[COORD_W-1:0];
  endfunction

endpackage

// File: rtl/core/skeletal_vertex_transform_core.sv
// ----------------------------------------------------------------------------
// skeletal_vertex_transform_core
// command-driven pivot, translate, rotate and scale of one vertex per word
// ----------------------------------------------------------------------------
// One input word is taken at a time and the core stalls its input until
// that word's work is done; unused command codes do no work. Rotate uses
// the single shared 23x18 multiplier four times per axis behind a
// registered trig rom read; finish pivot runs the one-bit-a-cycle
// restoring divider for 32 steps on each of the three axes. Results sit in
// an output register, so a new word is accepted while the last result
// still waits on a stalled output.
module skeletal_vertex_transform_core (
  input  logic               clk,
  input  logic               rst,
  // input word channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic signed [19:0] vertex_x,
  input  logic signed [19:0] vertex_y,
  input  logic signed [19:0] vertex_z,
  input  logic signed [15:0] param_x,
  input  logic signed [15:0] param_y,
  input  logic signed [15:0] param_z,
  // result word channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] out_x,
  output logic signed [19:0] out_y,
  output logic signed [19:0] out_z
);

  // sequencer to datapath command and divider status
  svt_pkg::dp_cmd_t cmd;
  logic             load;
  logic             div_done;

  // sequencer: owns both handshakes
  svt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .load      (load),
    .cmd       (cmd),
    .div_done  (div_done)
  );

  // datapath: pivot state, rom, multiplier, divider, output register
  svt_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .cmd      (cmd),
    .vertex_x (vertex_x),
    .vertex_y (vertex_y),
    .vertex_z (vertex_z),
    .param_x  (param_x),
    .param_y  (param_y),
    .param_z  (param_z),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .div_done (div_done)
  );

endmodule

// File: rtl/core/svt_datapath.sv
// ----------------------------------------------------------------------------
// svt_datapath
// pivot state, divider, trig rom, shared multiplier and result registers
// ----------------------------------------------------------------------------
module svt_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  svt_pkg::dp_cmd_t             cmd,
  input  logic signed [19:0]           vertex_x,
  input  logic signed [19:0]           vertex_y,
  input  logic signed [19:0]           vertex_z,
  input  logic signed [15:0]           param_x,
  input  logic signed [15:0]           param_y,
  input  logic signed [15:0]           param_z,
  output logic signed [19:0]           out_x,
  output logic signed [19:0]           out_y,
  output logic signed [19:0]           out_z,
  output logic                         div_done
);

  localparam svt_pkg::qrom_t QROM = svt_pkg::build_qrom();

  logic signed [19:0] vx, vy, vz;
  logic signed [15:0] px, py, pz;
  logic signed [svt_pkg::D_W-1:0] dx, dy, dz;
  logic signed [19:0] pivot_x, pivot_y, pivot_z;
  logic signed [svt_pkg::SUM_W-1:0] sum_x, sum_y, sum_z;
  logic [svt_pkg::COUNT_W-1:0] group_count;
  logic signed [19:0] res_x, res_y, res_z;

  logic [31:0] div_q;
  logic [svt_pkg::COUNT_W-1:0] div_rem;
  logic div_neg;
  logic [svt_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [svt_pkg::TRIG_VAL_W-1:0] sin_raw, cos_raw;
  logic sin_neg, cos_neg;
  logic signed [svt_pkg::MUL_B_W-1:0] s_val, c_val;

  logic signed [svt_pkg::PROD_W-1:0] prod;
  logic signed [svt_pkg::PROD_W:0] acc;
  logic signed [svt_pkg::D_W-1:0] wn;

  // selections
  logic signed [svt_pkg::SUM_W-1:0] sel_sum;
  logic signed [15:0] sel_p;
  logic signed [svt_pkg::D_W-1:0] sel_d, u, w;
  logic signed [19:0] sel_pivot;
  logic [7:0] angle;
  logic [svt_pkg::TRIG_W-1:0] sin_idx, cos_idx;
  logic signed [svt_pkg::D_W-1:0] mul_a;
  logic signed [svt_pkg::MUL_B_W-1:0] mul_b;
  logic [svt_pkg::COUNT_W:0] rem_sh;
  logic rem_ge;
  logic signed [33:0] quo_s;
  logic signed [svt_pkg::PROD_W:0] sum_term;
  logic signed [svt_pkg::PROD_W-1:0] prod_adj;
  logic signed [19:0] end_val, sc_val;

  function automatic logic [svt_pkg::QADDR_W-1:0] qaddr(input logic [svt_pkg::TRIG_W-1:0] i);
    logic [svt_pkg::QADDR_W-1:0] r;
    r = {1'b0, i[svt_pkg::TRIG_W-3:0]};
    return i[svt_pkg::TRIG_W-2] ? svt_pkg::QADDR_W'(svt_pkg::QUARTER) - r : r;
  endfunction

  always_comb begin
    unique case (cmd.axis)
      2'd0:    begin sel_sum = sum_x; sel_p = px; sel_pivot = pivot_x; end
      2'd1:    begin sel_sum = sum_y; sel_p = py; sel_pivot = pivot_y; end
      default: begin sel_sum = sum_z; sel_p = pz; sel_pivot = pivot_z; end
    endcase
    unique case (cmd.axis)
      2'd0:    sel_d = dx;
      2'd1:    sel_d = dy;
      default: sel_d = dz;
    endcase
    // rotation stages run z, then x, then y
    unique case (cmd.axis)
      2'd0:    begin u = dy; w = dx; angle = pz[7:0]; end
      2'd1:    begin u = dy; w = dz; angle = px[7:0]; end
      default: begin u = dz; w = dx; angle = py[7:0]; end
    endcase
  end

  assign sin_idx = {angle, 3'b000};
  assign cos_idx = sin_idx + svt_pkg::TRIG_W'(svt_pkg::QUARTER);

  assign s_val = sin_neg ? -$signed({1'b0, sin_raw}) : $signed({1'b0, sin_raw});
  assign c_val = cos_neg ? -$signed({1'b0, cos_raw}) : $signed({1'b0, cos_raw});

  always_comb begin
    mul_a = sel_d;
    mul_b = svt_pkg::MUL_B_W'(sel_p);
    if (cmd.op == svt_pkg::OP_ROT) begin
      case (cmd.step)
        3'd0:    begin mul_a = w; mul_b = c_val; end
        3'd1:    begin mul_a = u; mul_b = s_val; end
        3'd2:    begin mul_a = u; mul_b = c_val; end
        default: begin mul_a = w; mul_b = s_val; end
      endcase
    end
  end

  assign rem_sh = {div_rem, div_q[31]};
  assign rem_ge = rem_sh >= {1'b0, group_count};
  assign div_done = (div_cnt == svt_pkg::DIV_CNT_W'(svt_pkg::DIV_STEPS - 1));

  assign quo_s = div_neg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
  assign end_val = (group_count == '0) ? 20'(sel_p)
                 : svt_pkg::sat_coord(48'(quo_s + 34'(sel_p)));

  assign sum_term = (cmd.step == 3'd2) ? acc + 42'(prod) : acc - 42'(prod);

  assign prod_adj = prod + (prod[svt_pkg::PROD_W-1] ? 41'sd127 : 41'sd0);
  assign sc_val = svt_pkg::sat_coord(48'($signed(prod_adj[svt_pkg::PROD_W-1:7])) +
                                     48'(sel_pivot));

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_x <= '0; pivot_y <= '0; pivot_z <= '0;
      sum_x <= '0; sum_y <= '0; sum_z <= '0;
      group_count <= '0;
    end else begin
      if (cmd.op == svt_pkg::OP_ACC &&
          group_count < svt_pkg::COUNT_W'(svt_pkg::MAX_GROUP_VERTICES)) begin
        sum_x <= sum_x + 33'(vx);
        sum_y <= sum_y + 33'(vy);
        sum_z <= sum_z + 33'(vz);
        group_count <= group_count + 1'b1;
      end
      if (cmd.op == svt_pkg::OP_DIV_END) begin
        unique case (cmd.axis)
          2'd0:    pivot_x <= end_val;
          2'd1:    pivot_y <= end_val;
          default: pivot_z <= end_val;
        endcase
      end
      if (cmd.op == svt_pkg::OP_CLEAR) begin
        sum_x <= '0; sum_y <= '0; sum_z <= '0;
        group_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vx <= vertex_x; vy <= vertex_y; vz <= vertex_z;
      px <= param_x;  py <= param_y;  pz <= param_z;
      dx <= 23'(vertex_x) - 23'(pivot_x);
      dy <= 23'(vertex_y) - 23'(pivot_y);
      dz <= 23'(vertex_z) - 23'(pivot_z);
    end
    prod <= mul_a * mul_b;
    case (cmd.op)
      svt_pkg::OP_DIV_INIT: begin
        div_neg <= sel_sum[svt_pkg::SUM_W-1];
        div_q   <= sel_sum[svt_pkg::SUM_W-1] ? 32'(-sel_sum) : 32'(sel_sum);
        div_rem <= '0;
        div_cnt <= '0;
      end
      svt_pkg::OP_DIV_STEP: begin
        div_rem <= rem_ge ? svt_pkg::COUNT_W'(rem_sh - {1'b0, group_count})
                          : rem_sh[svt_pkg::COUNT_W-1:0];
        div_q   <= {div_q[30:0], rem_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      svt_pkg::OP_TRANS: begin
        res_x <= svt_pkg::sat_coord(48'(vx) + 48'(px));
        res_y <= svt_pkg::sat_coord(48'(vy) + 48'(py));
        res_z <= svt_pkg::sat_coord(48'(vz) + 48'(pz));
      end
      svt_pkg::OP_ROM: begin
        sin_raw <= QROM[qaddr(sin_idx)];
        cos_raw <= QROM[qaddr(cos_idx)];
        sin_neg <= sin_idx[svt_pkg::TRIG_W-1];
        cos_neg <= cos_idx[svt_pkg::TRIG_W-1];
      end
      svt_pkg::OP_ROT: begin
        case (cmd.step)
          3'd1, 3'd3: acc <= 42'(prod);
          3'd2:       wn <= sum_term[38:16];
          3'd4: begin
            unique case (cmd.axis)
              2'd0:    begin dx <= wn; dy <= sum_term[38:16]; end
              2'd1:    begin dz <= wn; dy <= sum_term[38:16]; end
              default: begin dx <= wn; dz <= sum_term[38:16]; end
            endcase
          end
          default: ;
        endcase
      end
      svt_pkg::OP_ROT_OUT: begin
        res_x <= svt_pkg::sat_coord(48'(dx) + 48'(pivot_x));
        res_y <= svt_pkg::sat_coord(48'(dy) + 48'(pivot_y));
        res_z <= svt_pkg::sat_coord(48'(dz) + 48'(pivot_z));
      end
      svt_pkg::OP_SC_ADD: begin
        unique case (cmd.axis)
          2'd0:    res_x <= sc_val;
          2'd1:    res_y <= sc_val;
          default: res_z <= sc_val;
        endcase
      end
      svt_pkg::OP_PUB: begin
        out_x <= res_x; out_y <= res_y; out_z <= res_z;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/svt_ctrl.sv
// ----------------------------------------------------------------------------
// svt_ctrl
// sequencer of the transform core and output word handshake
// ----------------------------------------------------------------------------
module svt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        command,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              load,
  output svt_pkg::dp_cmd_t  cmd,
  input  logic              div_done
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_DIV_INIT, S_DIV_STEP, S_DIV_END, S_CLEAR, S_TRANS,
    S_ROM, S_ROT, S_ROT_OUT, S_SC_MUL, S_SC_ADD, S_PUB
  } state_t;

  state_t     state;
  logic [1:0] axis;
  logic [2:0] step;
  logic       pub_ok;

  assign in_stall = (state != S_IDLE);
  assign load     = in_valid && (state == S_IDLE);
  assign pub_ok   = !out_valid || !out_stall;

  always_comb begin
    cmd.axis = axis;
    cmd.step = step;
    unique case (state)
      S_ACC:      cmd.op = svt_pkg::OP_ACC;
      S_DIV_INIT: cmd.op = svt_pkg::OP_DIV_INIT;
      S_DIV_STEP: cmd.op = svt_pkg::OP_DIV_STEP;
      S_DIV_END:  cmd.op = svt_pkg::OP_DIV_END;
      S_CLEAR:    cmd.op = svt_pkg::OP_CLEAR;
      S_TRANS:    cmd.op = svt_pkg::OP_TRANS;
      S_ROM:      cmd.op = svt_pkg::OP_ROM;
      S_ROT:      cmd.op = svt_pkg::OP_ROT;
      S_ROT_OUT:  cmd.op = svt_pkg::OP_ROT_OUT;
      S_SC_MUL:   cmd.op = svt_pkg::OP_SC_MUL;
      S_SC_ADD:   cmd.op = svt_pkg::OP_SC_ADD;
      S_PUB:      cmd.op = pub_ok ? svt_pkg::OP_PUB : svt_pkg::OP_NONE;
      default:    cmd.op = svt_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      // a published word replaces the one leaving in the same cycle
      if (state == S_PUB && pub_ok) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          axis <= '0;
          step <= '0;
          if (in_valid) begin
            unique case (command)
              svt_pkg::CMD_ACC:    state <= S_ACC;
              svt_pkg::CMD_FINISH: state <= S_DIV_INIT;
              svt_pkg::CMD_TRANS:  state <= S_TRANS;
              svt_pkg::CMD_ROT:    state <= S_ROM;
              svt_pkg::CMD_SCALE:  state <= S_SC_MUL;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_ACC:      state <= S_IDLE;
        S_DIV_INIT: state <= S_DIV_STEP;
        S_DIV_STEP: if (div_done) state <= S_DIV_END;
        S_DIV_END: begin
          if (axis == 2'd2) begin
            state <= S_CLEAR;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_DIV_INIT;
          end
        end
        S_CLEAR:    state <= S_IDLE;
        S_TRANS:    state <= S_PUB;
        S_ROM: begin
          step  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (step != 3'd4) begin
            step <= step + 1'b1;
          end else if (axis == 2'd2) begin
            state <= S_ROT_OUT;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_ROM;
          end
        end
        S_ROT_OUT:  state <= S_PUB;
        S_SC_MUL:   state <= S_SC_ADD;
        S_SC_ADD: begin
          if (axis == 2'd2) begin
            state <= S_PUB;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_SC_MUL;
          end
        end
        S_PUB: begin
          if (pub_ok) state <= S_IDLE;
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/svt_checker.sv
// ----------------------------------------------------------------------------
// svt_checker
// port-level checks on the transform core, bound to the top level
// ----------------------------------------------------------------------------
`include "skeletal_vertex_transform_core_macros.svh"

module svt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         command,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [19:0] out_x,
  input logic signed [19:0] out_y,
  input logic signed [19:0] out_z
);

  // a stalled result word stays offered
  `SVT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // a stalled result word keeps its value
  `SVT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable({out_x, out_y, out_z}))

  // any known command keeps the core busy the cycle after acceptance
  `SVT_ASSERT_NEXT(a_busy_after, in_valid && !in_stall && command <= svt_pkg::CMD_SCALE, in_stall)

  // an accumulate word never raises a result
  `SVT_ASSERT_NEXT(a_acc_silent, in_valid && !in_stall && command == svt_pkg::CMD_ACC, !$rose(out_valid))

endmodule

bind skeletal_vertex_transform_core svt_checker u_svt_checker (.*);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// skeletal vertex transform core testbench
// drives command words with random bursts and gaps, predicts each result from
// an independent model of pivot, translate, rotate and scale, checks outputs
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  localparam logic [2:0] CMD_SPARE     = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_TOP = 3'd7;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [19:0] vx, vy, vz;
    logic signed [15:0] px, py, pz;
  } vertex_word_t;

  typedef struct {
    logic signed [19:0] x, y, z;
  } coord_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command = '0;
  logic signed [19:0] vertex_x = '0, vertex_y = '0, vertex_z = '0;
  logic signed [15:0] param_x = '0, param_y = '0, param_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [19:0] out_x, out_y, out_z;

  skeletal_vertex_transform_core i_dut (
    .clk, .rst, .in_valid, .in_stall, .command,
    .vertex_x, .vertex_y, .vertex_z, .param_x, .param_y, .param_z,
    .out_valid, .out_stall, .out_x, .out_y, .out_z
  );

  always #4 clk = ~clk;

  // predictor state: pivot, running sums and vertex count
  longint pivot_q [3];
  longint group_sum [3];
  int     group_n;
  longint sine_quarter [svt_pkg::QUARTER+1];

  vertex_word_t pending_words [$];
  coord_t       expected_coords [$];
  int  error_count = 0;
  int  stall_cycles = 0;
  bit  stimulus_done = 1'b0;
  bit  hold_sender = 1'b0;
  bit  in_taken = 1'b0;

  // quarter sine table, unsigned 1.16 truncated toward zero
  function automatic longint quarter_sine_entry(int k);
    real a;
    if (k == svt_pkg::QUARTER) return 65536;
    a = $sin(3.14159265358979323846 * k / (2.0 * svt_pkg::QUARTER)) * 65536.0;
    return longint'($rtoi(a));
  endfunction

  function automatic longint trig_sine(int idx);
    int i, q, r;
    i = idx & (svt_pkg::TRIG_ENTRIES - 1);
    q = i / svt_pkg::QUARTER;
    r = i % svt_pkg::QUARTER;
    case (q)
      0: return sine_quarter[r];
      1: return sine_quarter[svt_pkg::QUARTER - r];
      2: return -sine_quarter[r];
      default: return -sine_quarter[svt_pkg::QUARTER - r];
    endcase
  endfunction

  // arithmetic shift is a floor for signed longint
  function automatic longint fix_floor(longint v);
    return v >>> 16;
  endfunction

  function automatic logic signed [19:0] clamp_coord(longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[19:0];
  endfunction

  task automatic queue_word(input vertex_word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  // applies one word to the predictor, queues a coordinate if one results
  task automatic transform_vertex(input vertex_word_t w);
    longint v [3];
    longint p [3];
    longint r [3];
    longint s, c, t, dx, dy, dz;
    coord_t res;
    v[0] = w.vx; v[1] = w.vy; v[2] = w.vz;
    p[0] = w.px; p[1] = w.py; p[2] = w.pz;
    case (w.cmd)
      svt_pkg::CMD_ACC: begin
        if (group_n < svt_pkg::MAX_GROUP_VERTICES) begin
          for (int a = 0; a < 3; a++) group_sum[a] += v[a];
          group_n++;
        end
        return;
      end
      svt_pkg::CMD_FINISH: begin
        for (int a = 0; a < 3; a++) begin
          if (group_n > 0) p[a] += group_sum[a] / group_n;
          pivot_q[a] = clamp_coord(p[a]);
          group_sum[a] = 0;
        end
        group_n = 0;
        return;
      end
      svt_pkg::CMD_TRANS: for (int a = 0; a < 3; a++) r[a] = v[a] + p[a];
      svt_pkg::CMD_ROT: begin
        dx = v[0] - pivot_q[0];
        dy = v[1] - pivot_q[1];
        dz = v[2] - pivot_q[2];
        // z axis first
        s = trig_sine(w.pz[7:0] * 8);
        c = trig_sine(w.pz[7:0] * 8 + svt_pkg::QUARTER);
        t = fix_floor(dy * s + dx * c);
        dy = fix_floor(dy * c - dx * s);
        dx = t;
        // then x
        s = trig_sine(w.px[7:0] * 8);
        c = trig_sine(w.px[7:0] * 8 + svt_pkg::QUARTER);
        t = fix_floor(dy * c - dz * s);
        dz = fix_floor(dy * s + dz * c);
        dy = t;
        // then y
        s = trig_sine(w.py[7:0] * 8);
        c = trig_sine(w.py[7:0] * 8 + svt_pkg::QUARTER);
        t = fix_floor(dz * s + dx * c);
        dz = fix_floor(dz * c - dx * s);
        dx = t;
        r[0] = dx + pivot_q[0];
        r[1] = dy + pivot_q[1];
        r[2] = dz + pivot_q[2];
      end
      svt_pkg::CMD_SCALE: for (int a = 0; a < 3; a++)
        r[a] = (v[a] - pivot_q[a]) * p[a] / 128 + pivot_q[a];
      default: return;
    endcase
    res.x = clamp_coord(r[0]);
    res.y = clamp_coord(r[1]);
    res.z = clamp_coord(r[2]);
    expected_coords.insert(expected_coords.size(), res);
  endtask

  function automatic logic signed [19:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return -20'sd524288;
      1: return 20'sd524287;
      2: return 20'($urandom_range(0, 4000)) - 20'sd2000;
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_param();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'($urandom_range(0, 512)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vertex_word_t make_word(logic [2:0] cmd);
    vertex_word_t w;
    w.cmd = cmd;
    w.vx = pick_coord(); w.vy = pick_coord(); w.vz = pick_coord();
    w.px = pick_param(); w.py = pick_param(); w.pz = pick_param();
    return w;
  endfunction

  function automatic vertex_word_t fixed_word(logic [2:0] cmd, int v, int p);
    vertex_word_t w;
    w.cmd = cmd;
    w.vx = 20'(v); w.vy = 20'(v); w.vz = 20'(v);
    w.px = 16'(p); w.py = 16'(p); w.pz = 16'(p);
    return w;
  endfunction

  // input handshake seen at the rising edge
  always @(posedge clk) in_taken <= in_valid && !in_stall;

  // driver: bursts of random length with random gaps, changes on the falling edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        // offered word was taken at the last rising edge
        transform_vertex(pending_words.pop_front());
      end
      if (!in_valid || in_taken) begin
        if (gap_left > 0 || hold_sender || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          command  <= pending_words[0].cmd;
          vertex_x <= pending_words[0].vx;
          vertex_y <= pending_words[0].vy;
          vertex_z <= pending_words[0].vz;
          param_x  <= pending_words[0].px;
          param_y  <= pending_words[0].py;
          param_z  <= pending_words[0].pz;
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
        end
      end
      // receiver stall pattern: an independent random stall draw on every falling edge
      out_stall <= ($urandom_range(0, 255) < 128) ? ($urandom_range(0, 3) == 0) : 1'b0;
    end
  end

  // monitor: sample at the rising edge, compare against the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_coords.size() == 0) begin
          $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time, out_x, out_y, out_z);
          error_count++;
        end else begin
          coord_t e;
          e = expected_coords.pop_front();
          if (out_x !== e.x) begin
            $display("%0t: x mismatch expected %0d actual %0d", $time, e.x, out_x);
            error_count++;
          end
          if (out_y !== e.y) begin
            $display("%0t: y mismatch expected %0d actual %0d", $time, e.y, out_y);
            error_count++;
          end
          if (out_z !== e.z) begin
            $display("%0t: z mismatch expected %0d actual %0d", $time, e.z, out_z);
            error_count++;
          end
        end
      end
      // watchdog on cycles with no handshake on either side
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    vertex_word_t w;
    for (int k = 0; k <= svt_pkg::QUARTER; k++) sine_quarter[k] = quarter_sine_entry(k);
    for (int a = 0; a < 3; a++) begin
      pivot_q[a] = 0;
      group_sum[a] = 0;
    end
    group_n = 0;

    // directed: finish with empty group, extremes, every command, spare codes
    queue_word(fixed_word(svt_pkg::CMD_ROT, 1000, 0));
    queue_word(fixed_word(svt_pkg::CMD_FINISH, 0, 16'sh7fff));
    queue_word(fixed_word(svt_pkg::CMD_TRANS, 524287, 32767));
    queue_word(fixed_word(svt_pkg::CMD_TRANS, -524288, -32768));
    queue_word(fixed_word(svt_pkg::CMD_SCALE, 524287, 32767));
    queue_word(fixed_word(svt_pkg::CMD_SCALE, -524288, -32768));
    queue_word(fixed_word(svt_pkg::CMD_ACC, 524287, 0));
    queue_word(fixed_word(svt_pkg::CMD_ACC, 524287, 0));
    queue_word(fixed_word(svt_pkg::CMD_ACC, -7, 0));
    queue_word(fixed_word(svt_pkg::CMD_FINISH, 0, 32767));
    queue_word(fixed_word(svt_pkg::CMD_ROT, -524288, 16'sh00ff));
    queue_word(fixed_word(svt_pkg::CMD_ROT, 524287, 16'sh0040));
    queue_word(fixed_word(svt_pkg::CMD_ROT, 12345, 16'shff80));
    queue_word(fixed_word(svt_pkg::CMD_ACC, -524288, 0));
    queue_word(fixed_word(svt_pkg::CMD_ACC, -3, 0));
    queue_word(fixed_word(svt_pkg::CMD_FINISH, 0, -32768));
    queue_word(fixed_word(svt_pkg::CMD_SCALE, 100, -1));
    queue_word(fixed_word(CMD_SPARE, 5, 5));
    queue_word(fixed_word(CMD_SPARE_TOP, -1, -1));
    queue_word(fixed_word(CMD_SPARE_MID, 0, 0));
    queue_word(fixed_word(svt_pkg::CMD_TRANS, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // wait until the directed results have drained, then hold the sender idle
    wait (pending_words.size() == 0 && expected_coords.size() == 0);
    @(negedge clk);
    hold_sender = 1'b1;
    repeat (120) @(posedge clk);
    hold_sender = 1'b0;

    // random: mostly well-formed groups followed by transforms, some noise
    for (int n = 0; n < 1900; ) begin
      int g;
      g = $urandom_range(0, 6);
      for (int k = 0; k < g; k++) begin
        queue_word(make_word(svt_pkg::CMD_ACC));
        n++;
      end
      queue_word(make_word(svt_pkg::CMD_FINISH));
      n++;
      for (int k = $urandom_range(1, 12); k > 0; k--) begin
        case ($urandom_range(0, 9))
          0, 1, 2: w = make_word(svt_pkg::CMD_TRANS);
          3, 4, 5, 6: w = make_word(svt_pkg::CMD_ROT);
          7, 8: w = make_word(svt_pkg::CMD_SCALE);
          default: w = make_word(3'($urandom_range(0, 7)));
        endcase
        queue_word(w);
        n++;
      end
      while (pending_words.size() > 200) @(posedge clk);
    end

    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_coords.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_coords.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
